// File: hdl/iefdo_pkg.sv
// Types and constants shared by the input event queue.
package iefdo_pkg;

  // Operation codes carried in the opcode field
  typedef enum logic [1:0] {
    OP_PUSH_KEY      = 2'd0,
    OP_PUSH_MOUSE    = 2'd1,
    OP_PUSH_CONSUMER = 2'd2,
    OP_POP           = 2'd3
  } op_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_KEY_TYPE      = 2'd0;
  localparam logic [1:0] CFG_MOUSE_TYPE    = 2'd1;
  localparam logic [1:0] CFG_CONSUMER_TYPE = 2'd2;

  // Reset values of the type code registers
  localparam logic [7:0] KEY_TYPE_RST      = 8'd1;
  localparam logic [7:0] MOUSE_TYPE_RST    = 8'd2;
  localparam logic [7:0] CONSUMER_TYPE_RST = 8'd3;

  // Length reported on every pop
  localparam logic [2:0] POP_REC_LEN = 3'd4;

  // Input word
  typedef struct packed {
    op_e                opcode;
    logic [7:0]         key_modifier;
    logic [7:0]         key_code;
    logic [7:0]         event_state;
    logic signed [7:0]  mouse_dx;
    logic signed [7:0]  mouse_dy;
    logic [7:0]         mouse_buttons;
    logic [15:0]        usage_code;
  } in_word_t;

  // Output word
  typedef struct packed {
    logic [7:0] event_type;
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic [7:0] byte_c;
    logic [2:0] record_len;
    logic       event_valid;
    logic       int_line;
  } out_word_t;

  // One stored event: type, then three payload bytes
  typedef struct packed {
    logic [7:0] ev_type;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
  } event_t;

endpackage

// File: hdl/input_event_fifo_drop_oldest.sv
// Ring queue of input events that drops the oldest entry when full.
//
//   channel   direction  handshake               payload
//   in        input      in_valid_i/in_ready_o   in_data_i   (in_word_t)
//   out       output     out_valid_o/out_ready_i out_data_o  (out_word_t)
//   cfg       input      cfg_we_i (no wait)      cfg_idx_i, cfg_wdata_i
//
// A push writes the event into the store, and the word lands in the output
// register at the accepting edge. A pop first registers the store read;
// the word is loaded from it while the pop is pending, and no input is
// taken then. Pushes run at one per cycle unless the output stalls.
// Reset clears pointers and output valid and reloads the type codes; the
// store itself is not cleared. A stalled output holds further input off.
module input_event_fifo_drop_oldest
  import iefdo_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PtrW-1:0] LastSlot = PtrW'(DEPTH - 1);

  // Type code registers
  logic [7:0] key_type_q, mouse_type_q, consumer_type_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_type_q      <= KEY_TYPE_RST;
      mouse_type_q    <= MOUSE_TYPE_RST;
      consumer_type_q <= CONSUMER_TYPE_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_KEY_TYPE)      key_type_q      <= cfg_wdata_i;
      if (cfg_idx_i == CFG_MOUSE_TYPE)    mouse_type_q    <= cfg_wdata_i;
      if (cfg_idx_i == CFG_CONSUMER_TYPE) consumer_type_q <= cfg_wdata_i;
    end
  end

  // Control state
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic            pop_pend_q, pop_pend_d;
  logic            pend_hit_q, pend_hit_d;   // pending pop found an event
  logic            pend_int_q, pend_int_d;   // interrupt level after the pop
  logic            out_valid_q, out_valid_d;
  out_word_t       out_q;

  logic   in_fire, is_push, is_pop, mem_we, mem_re;
  event_t push_ev, rd_data_q;
  logic [PtrW-1:0] wr_next, rd_next;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    bump = (p == LastSlot) ? '0 : p + 1'b1;
  endfunction

  assign in_ready_o = !pop_pend_q && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_pop     = (in_data_i.opcode == OP_POP);
  assign is_push    = in_fire && !is_pop;
  assign mem_we     = is_push;
  assign wr_next    = bump(wr_q);
  assign rd_next    = bump(rd_q);
  assign mem_re     = in_fire && is_pop && (rd_q != wr_q);

  // Assemble the event for a push
  always_comb begin
    push_ev = '0;
    unique case (in_data_i.opcode)
      OP_PUSH_KEY: begin
        push_ev = {key_type_q, in_data_i.key_modifier, in_data_i.key_code,
                   in_data_i.event_state};
      end
      OP_PUSH_MOUSE: begin
        push_ev = {mouse_type_q, in_data_i.mouse_dx, in_data_i.mouse_dy,
                   in_data_i.mouse_buttons};
      end
      OP_PUSH_CONSUMER: begin
        push_ev = {consumer_type_q, in_data_i.usage_code[7:0],
                   in_data_i.usage_code[15:8], in_data_i.event_state};
      end
      OP_POP: begin
        push_ev = '0;
      end
    endcase
  end

  // Pointer and pop bookkeeping
  always_comb begin
    wr_d       = wr_q;
    rd_d       = rd_q;
    pop_pend_d = 1'b0;
    pend_hit_d = pend_hit_q;
    pend_int_d = pend_int_q;
    if (in_fire && is_pop) begin
      pop_pend_d = 1'b1;
      pend_hit_d = (rd_q != wr_q);
      if (rd_q != wr_q) rd_d = rd_next;
      pend_int_d = (rd_d == wr_q);
    end else if (is_push) begin
      // full: drop the oldest before writing
      if (wr_next == rd_q) rd_d = rd_next;
      wr_d = wr_next;
    end
  end

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (is_push || pop_pend_q) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q        <= '0;
      rd_q        <= '0;
      pop_pend_q  <= 1'b0;
      pend_hit_q  <= 1'b0;
      pend_int_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      wr_q        <= wr_d;
      rd_q        <= rd_d;
      pop_pend_q  <= pop_pend_d;
      pend_hit_q  <= pend_hit_d;
      pend_int_q  <= pend_int_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (is_push) begin
      out_q <= '{event_type: 8'd0, byte_a: 8'd0, byte_b: 8'd0, byte_c: 8'd0,
                 record_len: 3'd0, event_valid: 1'b0,
                 int_line: (wr_d == rd_d)};
    end else if (pop_pend_q) begin
      out_q.event_type  <= pend_hit_q ? rd_data_q.ev_type : 8'd0;
      out_q.byte_a      <= pend_hit_q ? rd_data_q.a : 8'd0;
      out_q.byte_b      <= pend_hit_q ? rd_data_q.b : 8'd0;
      out_q.byte_c      <= pend_hit_q ? rd_data_q.c : 8'd0;
      out_q.record_len  <= POP_REC_LEN;
      out_q.event_valid <= pend_hit_q;
      out_q.int_line    <= pend_int_q;
    end
  end

  // Event store: one write port, one registered read port
  event_t store_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (mem_we) store_mem[wr_q] <= push_ev;
    if (mem_re) rd_data_q <= store_mem[rd_q];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_pend_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_pend_q |-> !out_valid_q)
    else $error("pop pending while output register is occupied");

  a_pend_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_pend_q |=> out_valid_q && !pop_pend_q)
    else $error("pending pop did not load the output register");

  a_push_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_push |=> out_valid_q && !out_q.event_valid)
    else $error("push result missing");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_q <= LastSlot) && (rd_q <= LastSlot))
    else $error("slot pointer out of range");

  a_no_read_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("store read and write in one cycle");

endmodule

// File: sim/event_queue_checker.sv
// Checker for the input event queue: predicts each output word and compares it.
`timescale 1ns / 1ps

module event_queue_checker
  import iefdo_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_word_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_word_t   out_data_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned SlotW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Shadow of the event ring and its pointers
  event_t      ring [DEPTH];
  int unsigned oldest_slot;
  int unsigned free_slot;

  // Shadow of the type code registers
  logic [7:0] key_code_r;
  logic [7:0] mouse_code_r;
  logic [7:0] consumer_code_r;

  // Output words still owed by the block, oldest first
  out_word_t  owed_words [$];
  out_word_t  owed;

  // Write one event; a full ring loses its oldest entry first
  function automatic void store_event(event_t ev);
    int unsigned nxt;
    nxt = (free_slot + 1) % DEPTH;
    if (nxt == oldest_slot) begin
      oldest_slot = (oldest_slot + 1) % DEPTH;
    end
    ring[free_slot[SlotW-1:0]] = ev;
    free_slot = nxt;
  endfunction

  // Apply one input word to the shadow state and return the word it yields
  function automatic out_word_t predict_word(in_word_t w);
    out_word_t r;
    event_t    ev;
    r = '0;
    case (w.opcode)
      OP_PUSH_KEY: begin
        store_event({key_code_r, w.key_modifier, w.key_code, w.event_state});
      end
      OP_PUSH_MOUSE: begin
        // movement bytes are kept as raw two's complement bits
        store_event({mouse_code_r, w.mouse_dx, w.mouse_dy, w.mouse_buttons});
      end
      OP_PUSH_CONSUMER: begin
        store_event({consumer_code_r, w.usage_code[7:0], w.usage_code[15:8],
                     w.event_state});
      end
      default: begin
        // pop: empty ring gives zero bytes with valid low
        r.record_len = POP_REC_LEN;
        if (oldest_slot != free_slot) begin
          ev            = ring[oldest_slot[SlotW-1:0]];
          oldest_slot   = (oldest_slot + 1) % DEPTH;
          r.event_type  = ev.ev_type;
          r.byte_a      = ev.a;
          r.byte_b      = ev.b;
          r.byte_c      = ev.c;
          r.event_valid = 1'b1;
        end
      end
    endcase
    r.int_line = (oldest_slot == free_slot);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_slot     = 0;
      free_slot       = 0;
      key_code_r      = KEY_TYPE_RST;
      mouse_code_r    = MOUSE_TYPE_RST;
      consumer_code_r = CONSUMER_TYPE_RST;
      owed_words.delete();
      fail_count_o    = 0;
      pending_o       = 0;
    end else begin
      // Output side first: a word leaving now belongs to an earlier input
      if (out_valid_i && out_ready_i) begin
        if (owed_words.size() == 0) begin
          if (fail_count_o < 10) begin
            $display("unexpected word: type %02h a %02h b %02h c %02h len %0d valid %0b int %0b",
                     out_data_i.event_type, out_data_i.byte_a, out_data_i.byte_b,
                     out_data_i.byte_c, out_data_i.record_len, out_data_i.event_valid,
                     out_data_i.int_line);
          end
          fail_count_o++;
        end else begin
          owed = owed_words.pop_front();
          if (out_data_i.event_type !== owed.event_type ||
              out_data_i.byte_a !== owed.byte_a ||
              out_data_i.byte_b !== owed.byte_b ||
              out_data_i.byte_c !== owed.byte_c ||
              out_data_i.record_len !== owed.record_len ||
              out_data_i.event_valid !== owed.event_valid ||
              out_data_i.int_line !== owed.int_line) begin
            if (fail_count_o < 10) begin
              $display("mismatch exp: type %02h a %02h b %02h c %02h len %0d valid %0b int %0b",
                       owed.event_type, owed.byte_a, owed.byte_b, owed.byte_c,
                       owed.record_len, owed.event_valid, owed.int_line);
              $display("         got: type %02h a %02h b %02h c %02h len %0d valid %0b int %0b",
                       out_data_i.event_type, out_data_i.byte_a, out_data_i.byte_b,
                       out_data_i.byte_c, out_data_i.record_len, out_data_i.event_valid,
                       out_data_i.int_line);
            end
            fail_count_o++;
          end
        end
      end
      // Input side
      if (in_valid_i && in_ready_i) begin
        owed_words.push_back(predict_word(in_data_i));
      end
      // Register writes take effect for later words; spare index is dropped
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_KEY_TYPE:      key_code_r      = cfg_wdata_i;
          CFG_MOUSE_TYPE:    mouse_code_r    = cfg_wdata_i;
          CFG_CONSUMER_TYPE: consumer_code_r = cfg_wdata_i;
          default: ;
        endcase
      end
      pending_o = owed_words.size();
    end
  end

endmodule

// File: sim/input_event_fifo_drop_oldest_tb.sv
// Testbench top for the input event queue: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module input_event_fifo_drop_oldest_tb;
  import iefdo_pkg::*;

  localparam int unsigned QUEUE_DEPTH  = 32;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam logic [1:0]  CFG_SPARE    = 2'd3;  // no register behind it

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_word_t   in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_word_t  out_data;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_idx   = '0;
  logic [7:0] cfg_wdata = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned offered    = 0;
  int unsigned burst_left = 0;
  int unsigned stall_cycles;
  logic        hold_req   = 1'b0;

  always #1 clk_i = ~clk_i;

  input_event_fifo_drop_oldest #(
    .DEPTH(QUEUE_DEPTH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  event_queue_checker #(
    .DEPTH(QUEUE_DEPTH)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Directed word: the same three bytes feed key and mouse fields, usage the rest
  function automatic in_word_t word_of(op_e op, logic [7:0] f0, logic [7:0] f1,
                                       logic [7:0] f2, logic [15:0] usage);
    in_word_t w;
    w.opcode        = op;
    w.key_modifier  = f0;
    w.key_code      = f1;
    w.event_state   = f2;
    w.mouse_dx      = f0;
    w.mouse_dy      = f1;
    w.mouse_buttons = f2;
    w.usage_code    = usage;
    return w;
  endfunction

  // Random content in every field, opcode as given
  function automatic in_word_t random_word(op_e op);
    logic [95:0] raw;
    in_word_t    w;
    raw      = {$urandom, $urandom, $urandom};
    w        = raw[$bits(in_word_t)-1:0];
    w.opcode = op;
    return w;
  endfunction

  function automatic op_e random_push();
    return op_e'($urandom_range(0, 2));
  endfunction

  // Offer one word, hold it until taken, then maybe open a gap
  task automatic offer(in_word_t w);
    int unsigned gap;
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    offered++;
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                : $urandom_range(1, 40);
    end
  endtask

  // Register write; the enable drops for a cycle between writes
  task automatic write_cfg(logic [1:0] idx, logic [7:0] value);
    cfg_idx   <= idx;
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    @(negedge clk_i);
  endtask

  // Stop offering and let every owed word drain out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Random traffic: fill/drain runs, mixed push/pop noise and push/pop alternation
  task automatic run_random(int unsigned n);
    int unsigned target;
    int unsigned kind;
    int unsigned len;
    int unsigned pct;
    int unsigned k;
    target = offered + n;
    while (offered < target) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        len = $urandom_range(20, 40);
        for (k = 0; k < len; k++) offer(random_word(random_push()));
        len = len + $urandom_range(0, 3);
        for (k = 0; k < len; k++) offer(random_word(OP_POP));
      end else if (kind < 8) begin
        len = $urandom_range(10, 30);
        pct = $urandom_range(10, 90);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(1, 100) <= pct) begin
            offer(random_word(random_push()));
          end else begin
            offer(random_word(OP_POP));
          end
        end
      end else begin
        len = $urandom_range(6, 16);
        for (k = 0; k < len; k++) begin
          offer(random_word((k % 2 == 1) ? OP_POP : random_push()));
        end
      end
    end
  endtask

  // Receiver: changing stall patterns, plus one long hold-off on request
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 1) == 1);
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Watchdog: too long without any word moving ends the run
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed: empty pop, field extremes for each push kind, drain past empty
    offer(word_of(OP_POP, 8'h00, 8'h00, 8'h00, 16'h0000));
    offer(word_of(OP_PUSH_KEY, 8'h00, 8'h00, 8'h00, 16'h0000));
    offer(word_of(OP_PUSH_KEY, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
    offer(word_of(OP_PUSH_MOUSE, 8'h80, 8'h7F, 8'h00, 16'h0000));
    offer(word_of(OP_PUSH_MOUSE, 8'h7F, 8'h80, 8'hFF, 16'hFFFF));
    offer(word_of(OP_PUSH_MOUSE, 8'hFF, 8'h01, 8'h55, 16'h1234));
    offer(word_of(OP_PUSH_CONSUMER, 8'h00, 8'h00, 8'h00, 16'h0000));
    offer(word_of(OP_PUSH_CONSUMER, 8'h00, 8'h00, 8'hFF, 16'hFFFF));
    offer(word_of(OP_PUSH_CONSUMER, 8'hA5, 8'h5A, 8'h01, 16'h00FF));
    offer(word_of(OP_PUSH_CONSUMER, 8'h5A, 8'hA5, 8'h80, 16'hFF00));
    repeat (10) offer(word_of(OP_POP, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
    offer(word_of(OP_PUSH_KEY, 8'h02, 8'h04, 8'h01, 16'h0000));
    offer(word_of(OP_POP, 8'h00, 8'h00, 8'h00, 16'h0000));

    // Reset type codes; long receiver hold-off in the middle
    run_random(120);
    hold_req = 1'b1;
    run_random(180);

    wait_idle();
    write_cfg(CFG_KEY_TYPE, 8'hFF);
    write_cfg(CFG_MOUSE_TYPE, 8'h00);
    write_cfg(CFG_CONSUMER_TYPE, 8'h80);
    run_random(280);

    wait_idle();
    write_cfg(CFG_KEY_TYPE, 8'h00);
    write_cfg(CFG_MOUSE_TYPE, 8'hFF);
    write_cfg(CFG_CONSUMER_TYPE, 8'h7F);
    write_cfg(CFG_SPARE, 8'hA5);
    run_random(280);

    wait_idle();
    write_cfg(CFG_KEY_TYPE, 8'($urandom_range(0, 255)));
    write_cfg(CFG_MOUSE_TYPE, 8'($urandom_range(0, 255)));
    write_cfg(CFG_CONSUMER_TYPE, 8'($urandom_range(0, 255)));
    run_random(280);

    // Drain and settle
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
